// File: hdl/aarm_pkg.sv
// Package for the axis-angle rotation matrix block: widths, CORDIC table, types.
// No dependencies; every other file of the block but aarm_stream_if uses it by scoped names.
`timescale 1ns / 1ps
package aarm_pkg;

	localparam int TRIG_ITERATIONS = 16;
	localparam int ATAN_STEPS = 24;
	localparam int CORDIC_STEPS = (TRIG_ITERATIONS < ATAN_STEPS) ? TRIG_ITERATIONS : ATAN_STEPS;

	localparam int ANGLE_W = 17;
	localparam int AXIS_W = 16;
	localparam int ENTRY_W = 16;
	// CORDIC vector is Q2.30 plus growth headroom; angle accumulator in 2^-16 degree.
	localparam int VEC_W = 34;
	localparam int ZACC_W = 26;

	localparam logic signed [ANGLE_W:0] FULL_TURN = 18'sd46080;
	localparam logic signed [ANGLE_W:0] HALF_TURN = 18'sd23040;
	localparam logic signed [ANGLE_W:0] QUARTER_TURN = 18'sd11520;
	localparam logic signed [VEC_W-1:0] CORDIC_START = 34'sd652032874;
	localparam logic signed [ENTRY_W-1:0] OUT_MAX = 16'sd16384;
	localparam logic signed [ENTRY_W-1:0] OUT_MIN = -16'sd16384;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_deg;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
		logic signed [AXIS_W-1:0] axis_z;
	} in_item_t;

	typedef struct packed {
		logic signed [ENTRY_W-1:0] m00;
		logic signed [ENTRY_W-1:0] m01;
		logic signed [ENTRY_W-1:0] m02;
		logic signed [ENTRY_W-1:0] m10;
		logic signed [ENTRY_W-1:0] m11;
		logic signed [ENTRY_W-1:0] m12;
		logic signed [ENTRY_W-1:0] m20;
		logic signed [ENTRY_W-1:0] m21;
		logic signed [ENTRY_W-1:0] m22;
	} out_item_t;

	// State of one item inside the CORDIC pipeline.
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ZACC_W-1:0] z;
		logic flip;
		logic signed [AXIS_W-1:0] ax;
		logic signed [AXIS_W-1:0] ay;
		logic signed [AXIS_W-1:0] az;
	} cordic_t;

	// atan(2^-i) in units of 2^-16 degree.
	function automatic logic signed [ZACC_W-1:0] atan_deg16(input int i);
		logic signed [ZACC_W-1:0] r;
		case (i)
			0: r = 26'sd2949120;
			1: r = 26'sd1740967;
			2: r = 26'sd919879;
			3: r = 26'sd466944;
			4: r = 26'sd234379;
			5: r = 26'sd117304;
			6: r = 26'sd58666;
			7: r = 26'sd29335;
			8: r = 26'sd14668;
			9: r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/aarm_stream_if.sv
// Valid/ready channel interface carrying one item of a given payload type.
// Depends on aarm_pkg only through the payload types that users pass in.
`timescale 1ns / 1ps
interface aarm_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/aarm_cordic.sv
// Pipelined rotation-mode CORDIC in degrees: quadrant reduction, one stage per step,
// and rounding to Q1.14. Uses aarm_pkg for widths, the atan table and cordic_t.
`timescale 1ns / 1ps
module aarm_cordic (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input aarm_pkg::in_item_t in_item,
	output logic out_valid,
	output logic signed [aarm_pkg::ENTRY_W-1:0] c,
	output logic signed [aarm_pkg::ENTRY_W-1:0] s,
	output logic signed [aarm_pkg::AXIS_W-1:0] ax,
	output logic signed [aarm_pkg::AXIS_W-1:0] ay,
	output logic signed [aarm_pkg::AXIS_W-1:0] az
);
	localparam int N = aarm_pkg::CORDIC_STEPS;

	logic signed [aarm_pkg::ANGLE_W:0] a_wrap;
	logic signed [aarm_pkg::ANGLE_W:0] a_red;
	logic flip_red;
	aarm_pkg::cordic_t st_s1;
	logic vld_s1;
	aarm_pkg::cordic_t pipe_s2 [1:N];
	logic vld_s2 [1:N];
	logic signed [aarm_pkg::VEC_W-1:0] xr;
	logic signed [aarm_pkg::VEC_W-1:0] yr;
	logic signed [aarm_pkg::ENTRY_W-1:0] c_s3;
	logic signed [aarm_pkg::ENTRY_W-1:0] s_s3;
	logic signed [aarm_pkg::AXIS_W-1:0] ax_s3;
	logic signed [aarm_pkg::AXIS_W-1:0] ay_s3;
	logic signed [aarm_pkg::AXIS_W-1:0] az_s3;
	logic vld_s3;

	// Reduce the angle to [-90, 90] degrees; at most one turn is added or taken off.
	always_comb begin
		a_wrap = {in_item.angle_deg[aarm_pkg::ANGLE_W-1], in_item.angle_deg};
		if (a_wrap >= aarm_pkg::HALF_TURN) a_wrap = a_wrap - aarm_pkg::FULL_TURN;
		else if (a_wrap < -aarm_pkg::HALF_TURN) a_wrap = a_wrap + aarm_pkg::FULL_TURN;
		a_red = a_wrap;
		flip_red = 1'b0;
		if (a_wrap > aarm_pkg::QUARTER_TURN) begin
			a_red = a_wrap - aarm_pkg::HALF_TURN;
			flip_red = 1'b1;
		end else if (a_wrap < -aarm_pkg::QUARTER_TURN) begin
			a_red = a_wrap + aarm_pkg::HALF_TURN;
			flip_red = 1'b1;
		end
	end

	// First stage holds the reduced angle and the start vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1.x <= aarm_pkg::CORDIC_START;
			st_s1.y <= '0;
			st_s1.z <= aarm_pkg::ZACC_W'(a_red) <<< 9;
			st_s1.flip <= flip_red;
			st_s1.ax <= in_item.axis_x;
			st_s1.ay <= in_item.axis_y;
			st_s1.az <= in_item.axis_z;
		end
	end

	// One registered micro-rotation per step.
	for (genvar i = 0; i < N; i++) begin : g_step
		aarm_pkg::cordic_t cur;
		logic cur_v;

		// The first step reads the start register, the others the previous step.
		if (i == 0) begin : g_first
			assign cur = st_s1;
			assign cur_v = vld_s1;
		end else begin : g_next
			assign cur = pipe_s2[i];
			assign cur_v = vld_s2[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s2[i+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s2[i+1].flip <= cur.flip;
				pipe_s2[i+1].ax <= cur.ax;
				pipe_s2[i+1].ay <= cur.ay;
				pipe_s2[i+1].az <= cur.az;
				if (!cur.z[aarm_pkg::ZACC_W-1]) begin
					pipe_s2[i+1].x <= cur.x - (cur.y >>> i);
					pipe_s2[i+1].y <= cur.y + (cur.x >>> i);
					pipe_s2[i+1].z <= cur.z - aarm_pkg::atan_deg16(i);
				end else begin
					pipe_s2[i+1].x <= cur.x + (cur.y >>> i);
					pipe_s2[i+1].y <= cur.y - (cur.x >>> i);
					pipe_s2[i+1].z <= cur.z + aarm_pkg::atan_deg16(i);
				end
			end
		end
	end

	// Round to Q1.14 and undo the half-turn fold.
	always_comb begin
		xr = (pipe_s2[N].x + aarm_pkg::VEC_W'(32768)) >>> 16;
		yr = (pipe_s2[N].y + aarm_pkg::VEC_W'(32768)) >>> 16;
		if (pipe_s2[N].flip) begin
			xr = -xr;
			yr = -yr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3 <= xr[aarm_pkg::ENTRY_W-1:0];
			s_s3 <= yr[aarm_pkg::ENTRY_W-1:0];
			ax_s3 <= pipe_s2[N].ax;
			ay_s3 <= pipe_s2[N].ay;
			az_s3 <= pipe_s2[N].az;
		end
	end

	assign out_valid = vld_s3;
	assign c = c_s3;
	assign s = s_s3;
	assign ax = ax_s3;
	assign ay = ay_s3;
	assign az = az_s3;

	// The output valid bit follows the last rotation step on every advance.
	a_out_vld: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (vld_s3 == $past(vld_s2[N])))
		else $error("CORDIC valid bit lost or invented");
	// A stall holds the last stage.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv) |=> ($stable(vld_s3) && $stable(c_s3) && $stable(s_s3)))
		else $error("CORDIC output moved during stall");
	// Reduced angle lies within a quarter turn.
	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		(a_red <= aarm_pkg::QUARTER_TURN) && (a_red >= -aarm_pkg::QUARTER_TURN))
		else $error("angle reduction out of range");
endmodule

// File: hdl/aarm_matrix.sv
// Rodrigues matrix assembly: axis products, scaling by (1-c) and s, rounding, saturation.
// Uses aarm_pkg for widths and out_item_t; fed by aarm_cordic.
`timescale 1ns / 1ps
module aarm_matrix (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input logic signed [aarm_pkg::ENTRY_W-1:0] c,
	input logic signed [aarm_pkg::ENTRY_W-1:0] s,
	input logic signed [aarm_pkg::AXIS_W-1:0] ax,
	input logic signed [aarm_pkg::AXIS_W-1:0] ay,
	input logic signed [aarm_pkg::AXIS_W-1:0] az,
	output logic out_valid,
	output aarm_pkg::out_item_t out_item
);
	localparam int P_W = 32;
	localparam int SUM_W = 52;

	// Stage 1: pairwise axis products, omc and scaled sine terms.
	logic signed [P_W-1:0] pxx_s1, pyy_s1, pzz_s1, pxy_s1, pxz_s1, pyz_s1;
	logic signed [P_W-1:0] sx_s1, sy_s1, sz_s1;
	logic signed [17:0] omc_s1;
	logic signed [aarm_pkg::ENTRY_W-1:0] c_s1;
	logic v_s1;
	// Stage 2: Q42 terms.
	logic signed [SUM_W-1:0] dxx_s2, dyy_s2, dzz_s2, oxy_s2, oxz_s2, oyz_s2;
	logic signed [SUM_W-1:0] tx_s2, ty_s2, tz_s2, cd_s2;
	logic v_s2;
	// Stage 3: sums.
	logic signed [SUM_W-1:0] e_s3 [9];
	logic v_s3;
	aarm_pkg::out_item_t res_s4;
	logic v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxx_s1 <= ax * ax;
			pyy_s1 <= ay * ay;
			pzz_s1 <= az * az;
			pxy_s1 <= ax * ay;
			pxz_s1 <= ax * az;
			pyz_s1 <= ay * az;
			sx_s1 <= s * ax;
			sy_s1 <= s * ay;
			sz_s1 <= s * az;
			omc_s1 <= 18'sd16384 - 18'(c);
			c_s1 <= c;
		end
	end

	// The (1-c) products need up to 47 bits, so both operands are widened first.
	always_ff @(posedge clk) begin
		if (adv) begin
			dxx_s2 <= SUM_W'(omc_s1) * SUM_W'(pxx_s1);
			dyy_s2 <= SUM_W'(omc_s1) * SUM_W'(pyy_s1);
			dzz_s2 <= SUM_W'(omc_s1) * SUM_W'(pzz_s1);
			oxy_s2 <= SUM_W'(omc_s1) * SUM_W'(pxy_s1);
			oxz_s2 <= SUM_W'(omc_s1) * SUM_W'(pxz_s1);
			oyz_s2 <= SUM_W'(omc_s1) * SUM_W'(pyz_s1);
			tx_s2 <= SUM_W'(sx_s1) <<< 14;
			ty_s2 <= SUM_W'(sy_s1) <<< 14;
			tz_s2 <= SUM_W'(sz_s1) <<< 14;
			cd_s2 <= SUM_W'(c_s1) <<< 28;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s3[0] <= cd_s2 + dxx_s2;
			e_s3[1] <= oxy_s2 - tz_s2;
			e_s3[2] <= oxz_s2 + ty_s2;
			e_s3[3] <= oxy_s2 + tz_s2;
			e_s3[4] <= cd_s2 + dyy_s2;
			e_s3[5] <= oyz_s2 - tx_s2;
			e_s3[6] <= oxz_s2 - ty_s2;
			e_s3[7] <= oyz_s2 + tx_s2;
			e_s3[8] <= cd_s2 + dzz_s2;
		end
	end

	function automatic logic signed [aarm_pkg::ENTRY_W-1:0] round_sat(
		input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = (v + SUM_W'(134217728)) >>> 28;
		if (r > SUM_W'(aarm_pkg::OUT_MAX)) return aarm_pkg::OUT_MAX;
		if (r < SUM_W'(aarm_pkg::OUT_MIN)) return aarm_pkg::OUT_MIN;
		return r[aarm_pkg::ENTRY_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s4.m00 <= round_sat(e_s3[0]);
			res_s4.m01 <= round_sat(e_s3[1]);
			res_s4.m02 <= round_sat(e_s3[2]);
			res_s4.m10 <= round_sat(e_s3[3]);
			res_s4.m11 <= round_sat(e_s3[4]);
			res_s4.m12 <= round_sat(e_s3[5]);
			res_s4.m20 <= round_sat(e_s3[6]);
			res_s4.m21 <= round_sat(e_s3[7]);
			res_s4.m22 <= round_sat(e_s3[8]);
		end
	end

	assign out_valid = v_s4;
	assign out_item = res_s4;

	// Saturated entries stay within the Q1.14 unit range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (res_s4.m00 <= aarm_pkg::OUT_MAX && res_s4.m00 >= aarm_pkg::OUT_MIN))
		else $error("entry out of range");
	// Valid bits move only on advance.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv) |=> ($stable(v_s4) && $stable(res_s4)))
		else $error("matrix stage moved during stall");
	// The transposed off-diagonal pair sums to twice the (1-c)xy term.
	a_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2) |=> (e_s3[1] + e_s3[3] == ($past(oxy_s2) <<< 1)))
		else $error("off-diagonal pair mismatch");
endmodule

// File: hdl/axis_angle_rotation_matrix.sv
// Channel     | Dir | Payload
// in_ch       | in  | angle_deg (17b, 1/128 deg), axis_x/y/z (16b Q1.14)
// out_ch      | out | m00..m22 (16b Q1.14, saturated)
// One item per cycle is accepted while the output is not stalled; the registers in order are
// reduction, one stage per CORDIC step, rounding, four matrix stages.
// The whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage with nothing lost or repeated.
// Reset clears only the valid bits. Uses aarm_pkg, aarm_stream_if,
// aarm_cordic and aarm_matrix.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix (
	input logic clk,
	input logic arst_n,
	aarm_stream_if.sink in_ch,
	aarm_stream_if.source out_ch
);
	logic adv;
	logic cv;
	logic signed [aarm_pkg::ENTRY_W-1:0] c, s;
	logic signed [aarm_pkg::AXIS_W-1:0] ax, ay, az;
	logic mv;
	aarm_pkg::out_item_t mi;

	// Advance while the last stage is empty or being taken.
	assign adv = !mv || out_ch.ready;
	assign in_ch.ready = adv;

	aarm_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(in_ch.valid), .in_item(in_ch.payload),
		.out_valid(cv), .c(c), .s(s), .ax(ax), .ay(ay), .az(az)
	);

	aarm_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(cv), .c(c), .s(s), .ax(ax), .ay(ay), .az(az),
		.out_valid(mv), .out_item(mi)
	);

	assign out_ch.valid = mv;
	assign out_ch.payload = mi;

	// A waiting result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.payload)))
		else $error("result dropped during stall");
	// Input is refused only while a result waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ch.ready) |-> (out_ch.valid && !out_ch.ready))
		else $error("input refused without back-pressure");
	// A stall holds the pipeline's output.
	a_valid_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_ch.valid) |-> $past(out_ch.ready))
		else $error("result vanished untaken");
endmodule

// File: verif/aarm_scoreboard.sv
// Scoreboard class for the axis-angle rotation matrix testbench: predicts the
// nine matrix entries of each accepted item and checks results in order. Uses aarm_pkg.
`timescale 1ns / 1ps
package aarm_tb_pkg;

	class rotation_scoreboard;
		aarm_pkg::out_item_t pending_matrices[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		static function longint floor_shr(longint v, int s);
			return v >>> s;
		endfunction

		static function longint round_clamp(longint sum);
			longint r;
			r = floor_shr(sum + (64'sd1 <<< 27), 28);
			if (r > 16384) r = 16384;
			if (r < -16384) r = -16384;
			return r;
		endfunction

		// Degree-based CORDIC with quadrant folding.
		static function void trig(longint units, output longint c, output longint s);
			longint a, x, y, z, dx, dy;
			bit flip;
			longint atan_tab[24];
			atan_tab = '{2949120, 1740967, 919879, 466944, 234379, 117304, 58666,
				29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
				4, 2, 1, 0};
			a = (units + 2 * 46080) % 46080;
			flip = 0;
			if (a >= 23040) a -= 46080;
			if (a > 11520) begin
				a -= 23040;
				flip = 1;
			end else if (a < -11520) begin
				a += 23040;
				flip = 1;
			end
			z = a * 512;
			x = 652032874;
			y = 0;
			for (int i = 0; i < aarm_pkg::TRIG_ITERATIONS && i < 24; i++) begin
				dx = floor_shr(y, i);
				dy = floor_shr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_tab[i];
				end else begin
					x += dx; y -= dy; z += atan_tab[i];
				end
			end
			x = floor_shr(x + (64'sd1 <<< 15), 16);
			y = floor_shr(y + (64'sd1 <<< 15), 16);
			if (flip) begin
				x = -x;
				y = -y;
			end
			c = x;
			s = y;
		endfunction

		// Note one accepted input item and queue its expected matrix.
		function void note_input(aarm_pkg::in_item_t it);
			longint c, s, omc, cd, ax, ay, az;
			aarm_pkg::out_item_t m;
			ax = it.axis_x;
			ay = it.axis_y;
			az = it.axis_z;
			trig(longint'(it.angle_deg), c, s);
			omc = 16384 - c;
			cd = c <<< 28;
			m.m00 = 16'(round_clamp(cd + omc * ax * ax));
			m.m01 = 16'(round_clamp(omc * ax * ay - s * az * 16384));
			m.m02 = 16'(round_clamp(omc * ax * az + s * ay * 16384));
			m.m10 = 16'(round_clamp(omc * ax * ay + s * az * 16384));
			m.m11 = 16'(round_clamp(cd + omc * ay * ay));
			m.m12 = 16'(round_clamp(omc * ay * az - s * ax * 16384));
			m.m20 = 16'(round_clamp(omc * ax * az - s * ay * 16384));
			m.m21 = 16'(round_clamp(omc * ay * az + s * ax * 16384));
			m.m22 = 16'(round_clamp(cd + omc * az * az));
			pending_matrices.push_back(m);
		endfunction

		function void cmp(string name, logic [15:0] e, logic [15:0] a);
			if (e !== a) begin
				$error("%s: expected %0d, got %0d", name, $signed(e), $signed(a));
				mismatches++;
			end
		endfunction

		// Check one accepted result against the oldest expected matrix.
		function void check_result(aarm_pkg::out_item_t got);
			aarm_pkg::out_item_t e;
			if (pending_matrices.size() == 0) begin
				$error("result: expected none, got m00=%0d", got.m00);
				mismatches++;
				return;
			end
			e = pending_matrices.pop_front();
			cmp("m00", e.m00, got.m00); cmp("m01", e.m01, got.m01);
			cmp("m02", e.m02, got.m02); cmp("m10", e.m10, got.m10);
			cmp("m11", e.m11, got.m11); cmp("m12", e.m12, got.m12);
			cmp("m20", e.m20, got.m20); cmp("m21", e.m21, got.m21);
			cmp("m22", e.m22, got.m22);
		endfunction
	endclass
endpackage

// File: verif/tb_top.sv
// Top of the axis-angle rotation matrix testbench: clock, reset, item driver,
// random output stalls and the final verdict. Uses aarm_pkg, aarm_stream_if, aarm_tb_pkg.
`timescale 1ns / 1ps
module tb_top;

	logic clk;
	logic arst_n;
	int cycle_count;
	bit idle_free;
	aarm_tb_pkg::rotation_scoreboard sb;

	aarm_stream_if #(.payload_t(aarm_pkg::in_item_t)) in_ch ();
	aarm_stream_if #(.payload_t(aarm_pkg::out_item_t)) out_ch ();

	axis_angle_rotation_matrix dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.payload = '0;
		out_ch.ready = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// Timeout guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("Mismatches found");
			$finish;
		end
	end
	initial cycle_count = 0;

	// Monitor accepted items on both channels.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.payload);
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
	end

	// Receiver stalls in random bursts until the quiet final stretch.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!idle_free && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 12);
				out_ch.ready <= 0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= 1;
		end
	end

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// Drive one item and hold it until accepted, with an optional gap before.
	task automatic send_item(logic signed [16:0] ang, logic signed [15:0] x,
		logic signed [15:0] y, logic signed [15:0] z);
		aarm_pkg::in_item_t it;
		if (!idle_free && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		it.angle_deg = ang;
		it.axis_x = x;
		it.axis_y = y;
		it.axis_z = z;
		in_ch.valid <= 1;
		in_ch.payload <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	initial begin
		int k;
		logic signed [16:0] ang;
		sb = new();
		idle_free = 0;
		@(posedge arst_n);
		@(posedge clk);
		// Directed items: angle extremes, wraps, quadrant edges, axis extremes.
		send_item(0, 16384, 0, 0);
		send_item(46080, 0, 16384, 0);
		send_item(-46080, 0, 0, 16384);
		send_item(65535, 16384, 16384, 16384);
		send_item(-65536, -16384, -16384, -16384);
		send_item(11520, 0, 0, 16384);
		send_item(-11520, 0, 0, 16384);
		send_item(11521, 9459, 9459, 9459);
		send_item(-11521, 9459, -9459, 9459);
		send_item(23040, 16384, 0, 0);
		send_item(-23040, 0, 16384, 0);
		send_item(23039, 0, 0, -16384);
		send_item(34560, 11585, 11585, 0);
		send_item(-1, 32767, -32768, 32767);
		send_item(1, -32768, 32767, -32768);
		send_item(5760, 0, 0, 0);
		send_item(46079, -1, -1, -1);
		send_item(-46079, 16'h5555, 16'shAAAA, 16'h5555);
		// Wait for every expected result before the random part.
		in_ch.valid <= 0;
		while (sb.pending_matrices.size() != 0) @(posedge clk);
		for (k = 0; k < 950; k++) begin
			if (k == 850) idle_free = 1;
			case ($urandom_range(0, 3))
				0: ang = 17'($urandom);
				default: ang = 17'($signed($urandom_range(0, 92160)) - 46080);
			endcase
			send_item(ang, rand_axis(), rand_axis(), rand_axis());
		end
		in_ch.valid <= 0;
		while (sb.pending_matrices.size() != 0) @(posedge clk);
		repeat (aarm_pkg::TRIG_ITERATIONS + 10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_matrices.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// File: files.f
hdl/aarm_pkg.sv
hdl/aarm_stream_if.sv
hdl/aarm_cordic.sv
hdl/aarm_matrix.sv
hdl/axis_angle_rotation_matrix.sv
verif/aarm_scoreboard.sv
verif/tb_top.sv
